// File: sv/planar_dead_reckoning_defines.svh
// Assertion helpers for the dead reckoning block
`ifndef PLANAR_DEAD_RECKONING_DEFINES_SVH
`define PLANAR_DEAD_RECKONING_DEFINES_SVH

// consequent holds in the cycle after the antecedent
`define PDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// consequent holds in the same cycle as the antecedent
`define PDR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

// File: sv/pdr_pkg.sv
package pdr_pkg;

  localparam int DIV_FIX_STEPS = 3;
  localparam logic [31:0] ANG_SCALE = 32'd2935890503;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

  typedef enum logic [3:0] {
    S_IDLE, S_MULDT, S_DT, S_MULA, S_MULLO, S_MULHI, S_SUM,
    S_CINIT, S_RUN, S_FIN, S_MULXY, S_ACC, S_OUT
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_dt;
    logic       calc_dt;
    logic       mul_a;
    logic       mul_lo;
    logic       mul_hi;
    logic       sum;
    logic       cinit;
    logic       div_q;
    logic       div_p;
    logic       div_r;
    logic       div_fix;
    logic       trig_en;
    logic [4:0] idx;
    logic       fin;
    logic       mul_xy;
    logic       acc;
    logic       load_out;
  } cmd_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: sv/pdr_cordic.sv
module pdr_cordic (
  input  logic               clk,
  input  logic               init,
  input  logic               step,
  input  logic [4:0]         idx,
  input  logic [31:0]        ang,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);
  import pdr_pkg::*;

  logic signed [33:0] x, y, z;
  logic               flip;
  logic [31:0]        ang_off;
  logic [31:0]        ang_rot;
  logic signed [33:0] xs, ys, xf, yf;
  logic [31:0]        at;

  assign ang_off = ang + 32'h40000000;
  assign ang_rot = ang_off[31] ? (ang ^ 32'h80000000) : ang;
  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = atan_lut(idx);

  always_ff @(posedge clk) begin
    if (init) begin
      flip <= ang_off[31];
      x <= CORDIC_GAIN;
      y <= '0;
      z <= 34'($signed(ang_rot));
    end else if (step) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - $signed({2'b00, at});
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + $signed({2'b00, at});
      end
    end
  end

  assign xf = flip ? -x : x;
  assign yf = flip ? -y : y;

  always_comb begin
    if (xf > ONE_Q30) cos_q = 32'(ONE_Q30);
    else if (xf < -ONE_Q30) cos_q = 32'(-ONE_Q30);
    else cos_q = xf[31:0];
    if (yf > ONE_Q30) sin_q = 32'(ONE_Q30);
    else if (yf < -ONE_Q30) sin_q = 32'(-ONE_Q30);
    else sin_q = yf[31:0];
  end

endmodule

// File: sv/pdr_datapath.sv
module pdr_datapath (
  input  logic               clk,
  input  logic               rst,
  input  pdr_pkg::cmd_t      cmd,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] forward_speed,
  input  logic signed [31:0] yaw_rate,
  input  logic [31:0]        stamp_sec,
  input  logic [29:0]        stamp_nsec,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [31:0] heading,
  output logic signed [31:0] quat_z,
  output logic signed [31:0] quat_w,
  output logic [31:0]        out_sec,
  output logic [29:0]        out_nsec,
  output logic               step_clamped
);
  import pdr_pkg::*;

  localparam logic signed [30:0] NS = 31'sd1000000000;
  localparam logic signed [63:0] DT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] DT_MIN = -64'sd2147483648;
  localparam logic [30:0] NS_U = 31'd1000000000;
  // floor(2^62 / 10^9)
  localparam logic [32:0] NS_RECIP = 33'd4611686018;
  localparam logic signed [48:0] POS_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] POS_MIN = -49'sh0_8000_0000_0000;

  logic signed [31:0] drift;
  logic signed [31:0] speed_r, yaw_r;
  logic [31:0]        sec_r, prev_sec;
  logic [29:0]        nsec_r, prev_nsec;
  logic               seen_first;
  logic signed [63:0] dsp;
  logic signed [31:0] dt_r;
  logic               clamped_r;
  logic signed [32:0] rate_r;
  logic [63:0]        prod_a;
  logic [62:0]        prod_d;
  logic               ang_neg, spd_neg;
  logic [63:0]        lo_r, hi_r;
  logic [31:0]        acc_heading;
  logic [62:0]        n_r;
  logic [63:0]        qn_r;
  logic [33:0]        dr, quo;
  logic signed [31:0] c_r, s_r, qw_r, qz_r;
  logic signed [35:0] mx_r, my_r;
  logic signed [47:0] acc_x, acc_y;

  logic signed [32:0] ds;
  logic signed [30:0] dn;
  logic signed [63:0] dt_full;
  logic [31:0]        mdt, smag;
  logic [32:0]        rmag;
  logic [63:0]        u, ur, nd;
  logic [31:0]        delta;
  logic [65:0]        qe;
  logic               dr_ge;
  logic signed [31:0] c0, s0, c1, s1;
  logic [30:0]        cmag, smg;
  logic [64:0]        px, py;
  logic [34:0]        mx, my;
  logic signed [48:0] sx, sy;

  assign ds = $signed({1'b0, sec_r}) - $signed({1'b0, prev_sec});
  assign dn = $signed({1'b0, nsec_r}) - $signed({1'b0, prev_nsec});
  assign dt_full = dsp + 64'(dn);
  assign mdt = dt_r[31] ? (~dt_r + 32'd1) : dt_r;
  assign rmag = rate_r[32] ? (~rate_r + 33'd1) : rate_r;
  assign smag = speed_r[31] ? (~speed_r + 32'd1) : speed_r;
  assign u = hi_r + {32'b0, lo_r[63:32]};
  assign ur = u + 64'd32768;
  assign delta = ur[47:16];
  assign nd = {1'b0, prod_d} + 64'd500000000;
  // quotient estimate is low by at most two, the fix steps bring it up
  assign qe = 66'(n_r[62:30]) * 66'(NS_RECIP);
  assign dr_ge = dr >= 34'(NS_U);
  assign cmag = c_r[31] ? 31'(-c_r) : c_r[30:0];
  assign smg = s_r[31] ? 31'(-s_r) : s_r[30:0];
  assign px = 65'(quo) * 65'(cmag) + 65'(33'h020000000);
  assign py = 65'(quo) * 65'(smg) + 65'(33'h020000000);
  assign mx = px[64:30];
  assign my = py[64:30];
  assign sx = 49'(acc_x) + 49'(mx_r);
  assign sy = 49'(acc_y) + 49'(my_r);

  pdr_cordic u_cordic_head (
    .clk   (clk),
    .init  (cmd.cinit),
    .step  (cmd.trig_en),
    .idx   (cmd.idx),
    .ang   (acc_heading),
    .cos_q (c0),
    .sin_q (s0)
  );

  pdr_cordic u_cordic_half (
    .clk   (clk),
    .init  (cmd.cinit),
    .step  (cmd.trig_en),
    .idx   (cmd.idx),
    .ang   ({acc_heading[31], acc_heading[31:1]}),
    .cos_q (c1),
    .sin_q (s1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      drift <= '0;
      prev_sec <= '0;
      prev_nsec <= '0;
      seen_first <= 1'b0;
      acc_heading <= '0;
      acc_x <= '0;
      acc_y <= '0;
    end else begin
      if (cfg_we) drift <= cfg_data;
      if (cmd.calc_dt) begin
        prev_sec <= sec_r;
        prev_nsec <= nsec_r;
        seen_first <= 1'b1;
      end
      if (cmd.sum) acc_heading <= acc_heading + (ang_neg ? (~delta + 32'd1) : delta);
      if (cmd.acc) begin
        if (sx > POS_MAX) acc_x <= POS_MAX[47:0];
        else if (sx < POS_MIN) acc_x <= POS_MIN[47:0];
        else acc_x <= sx[47:0];
        if (sy > POS_MAX) acc_y <= POS_MAX[47:0];
        else if (sy < POS_MIN) acc_y <= POS_MIN[47:0];
        else acc_y <= sy[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      speed_r <= forward_speed;
      yaw_r <= yaw_rate;
      sec_r <= stamp_sec;
      nsec_r <= stamp_nsec;
    end
    if (cmd.mul_dt) dsp <= ds * NS;
    if (cmd.calc_dt) begin
      rate_r <= 33'(yaw_r) - 33'(drift);
      clamped_r <= 1'b0;
      if (!seen_first) begin
        dt_r <= '0;
      end else if (dt_full > DT_MAX) begin
        dt_r <= DT_MAX[31:0];
        clamped_r <= 1'b1;
      end else if (dt_full < DT_MIN) begin
        dt_r <= DT_MIN[31:0];
        clamped_r <= 1'b1;
      end else begin
        dt_r <= dt_full[31:0];
      end
    end
    if (cmd.mul_a) begin
      prod_a <= 64'(rmag) * 64'(mdt);
      prod_d <= 63'(smag) * 63'(mdt);
      ang_neg <= rate_r[32] ^ dt_r[31];
      spd_neg <= speed_r[31] ^ dt_r[31];
    end
    if (cmd.mul_lo) lo_r <= 64'(prod_a[31:0]) * 64'(ANG_SCALE);
    if (cmd.mul_hi) hi_r <= 64'(prod_a[63:32]) * 64'(ANG_SCALE);
    if (cmd.sum) n_r <= nd[62:0];
    if (cmd.div_q) quo <= qe[65:32];
    else if (cmd.div_fix && dr_ge) quo <= quo + 34'd1;
    if (cmd.div_p) qn_r <= 64'(quo) * 64'(NS_U);
    if (cmd.div_r) dr <= 34'({1'b0, n_r} - qn_r);
    else if (cmd.div_fix && dr_ge) dr <= dr - 34'(NS_U);
    if (cmd.fin) begin
      c_r <= c0;
      s_r <= s0;
      qw_r <= c1;
      qz_r <= s1;
    end
    if (cmd.mul_xy) begin
      mx_r <= (spd_neg ^ c_r[31]) ? -$signed(36'(mx)) : $signed(36'(mx));
      my_r <= (spd_neg ^ s_r[31]) ? -$signed(36'(my)) : $signed(36'(my));
    end
    if (cmd.load_out) begin
      pos_x <= acc_x;
      pos_y <= acc_y;
      heading <= acc_heading;
      quat_z <= qz_r;
      quat_w <= qw_r;
      out_sec <= sec_r;
      out_nsec <= nsec_r;
      step_clamped <= clamped_r;
    end
  end

endmodule

// File: sv/pdr_ctrl.sv
module pdr_ctrl #(
  parameter int TRIG_ITERATIONS = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output pdr_pkg::state_t state,
  output pdr_pkg::cmd_t cmd
);
  import pdr_pkg::*;

  localparam int TRIG_N = TRIG_ITERATIONS > 32 ? 32 : TRIG_ITERATIONS;
  localparam int RUN_LEN = TRIG_N > DIV_FIX_STEPS + 2 ? TRIG_N : DIV_FIX_STEPS + 2;

  state_t     state_next;
  logic [5:0] cnt, cnt_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    cmd.idx = cnt[4:0];
    in_ready = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_MULDT;
        end
      end
      S_MULDT: begin
        cmd.mul_dt = 1'b1;
        state_next = S_DT;
      end
      S_DT: begin
        cmd.calc_dt = 1'b1;
        state_next = S_MULA;
      end
      S_MULA: begin
        cmd.mul_a = 1'b1;
        state_next = S_MULLO;
      end
      S_MULLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MULHI;
      end
      S_MULHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_next = S_CINIT;
      end
      S_CINIT: begin
        cmd.cinit = 1'b1;
        cmd.div_q = 1'b1;
        cnt_next = '0;
        state_next = S_RUN;
      end
      S_RUN: begin
        cmd.trig_en = cnt < 6'(TRIG_N);
        cmd.div_p = cnt == 6'd0;
        cmd.div_r = cnt == 6'd1;
        cmd.div_fix = cnt >= 6'd2 && cnt < 6'(DIV_FIX_STEPS + 2);
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(RUN_LEN - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_next = S_MULXY;
      end
      S_MULXY: begin
        cmd.mul_xy = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: sv/planar_dead_reckoning.sv
// From input accept to output valid, the longer of the CORDIC loop and the divide
//   by 10^9 sets the run time; the divide runs inside that loop.
// One word is computed at a time: a new word is accepted only in the idle state;
//   the next word is taken while the result waits.
// Reset (rst, synchronous, active high) clears pose, heading, stored stamp, drift
//   register and the first-sample flag.
module planar_dead_reckoning #(
  parameter int TRIG_ITERATIONS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] forward_speed,
  input  logic signed [31:0] yaw_rate,
  input  logic [31:0]        stamp_sec,
  input  logic [29:0]        stamp_nsec,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] pos_x,
  output logic signed [47:0] pos_y,
  output logic signed [31:0] heading,
  output logic signed [31:0] quat_z,
  output logic signed [31:0] quat_w,
  output logic [31:0]        out_sec,
  output logic [29:0]        out_nsec,
  output logic               step_clamped,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import pdr_pkg::*;
  `include "planar_dead_reckoning_defines.svh"

  cmd_t   cmd;
  state_t state;

  assign cfg_ready = 1'b1;

  pdr_ctrl #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .state     (state),
    .cmd       (cmd)
  );

  pdr_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .forward_speed (forward_speed),
    .yaw_rate      (yaw_rate),
    .stamp_sec     (stamp_sec),
    .stamp_nsec    (stamp_nsec),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .heading       (heading),
    .quat_z        (quat_z),
    .quat_w        (quat_w),
    .out_sec       (out_sec),
    .out_nsec      (out_nsec),
    .step_clamped  (step_clamped)
  );

  `PDR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `PDR_ASSERT_NEXT(a_out_from_done, cmd.load_out, out_valid && state == S_IDLE)
  `PDR_ASSERT_NOW(a_load_when_free, cmd.load_out, !out_valid || out_ready)

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [31:0] rate;
    logic [31:0]        sec;
    logic [29:0]        nsec;
  } odo_word_t;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [31:0] hdg;
    logic signed [31:0] qz;
    logic signed [31:0] qw;
    logic [31:0]        sec;
    logic [29:0]        nsec;
    logic               clamped;
  } pose_word_t;

  localparam int TRIG_N = 24;
  localparam longint POS_HI = 64'sh7FFFFFFFFFFF;
  localparam longint POS_LO = -64'sh800000000000;
  localparam longint DT_HI = 64'sd2147483647;
  localparam longint DT_LO = -64'sd2147483648;
  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic signed [31:0] forward_speed = 0, yaw_rate = 0;
  logic [31:0] stamp_sec = 0;
  logic [29:0] stamp_nsec = 0;
  logic out_valid, out_ready = 0;
  logic signed [47:0] pos_x, pos_y;
  logic signed [31:0] heading, quat_z, quat_w;
  logic [31:0] out_sec;
  logic [29:0] out_nsec;
  logic step_clamped;
  logic cfg_valid = 0, cfg_ready;
  logic [31:0] cfg_data = 0;

  planar_dead_reckoning #(.TRIG_ITERATIONS(TRIG_N)) uut (.*);

  always #5 clk = ~clk;

  odo_word_t  pending_odo[$];
  pose_word_t expected_pose[$];
  int errors = 0;
  int in_idle_pct = 0, out_stall_pct = 0;
  int idle_cycles = 0;
  logic [31:0] pending_cfg[$];
  bit in_taken = 0, cfg_taken = 0;

  // predictor state
  longint m_x = 0, m_y = 0;
  logic [31:0] m_hdg = 0, m_prev_sec = 0, m_drift = 0;
  logic [29:0] m_prev_nsec = 0;
  bit m_seen = 0;

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint umag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void rotate_trig(input logic [31:0] ang, output longint c,
                                      output longint s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, nx;
    a = ang;
    flip = 0;
    x = 652032874;
    y = 0;
    if (((a + 32'h40000000) & 32'h80000000) != 0) begin
      a = a + 32'h80000000;
      flip = 1;
    end
    z = longint'($signed(a));
    for (int i = 0; i < TRIG_N; i++) begin
      if (z >= 0) begin
        nx = x - asr64(y, i);
        y = y + asr64(x, i);
        z -= longint'(pdr_pkg::atan_lut(i[4:0]));
      end else begin
        nx = x + asr64(y, i);
        y = y - asr64(x, i);
        z += longint'(pdr_pkg::atan_lut(i[4:0]));
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x > 1073741824 ? 1073741824 : (x < -1073741824 ? -1073741824 : x);
    s = y > 1073741824 ? 1073741824 : (y < -1073741824 ? -1073741824 : y);
  endfunction

  function automatic longint pos_step(logic [63:0] dmag, bit dneg, longint t);
    logic [63:0] m;
    m = (dmag * 64'(umag(t)) + 64'd536870912) >> 30;
    return (dneg != (t < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat48(longint a, longint b);
    longint r;
    r = a + b;
    if (r > POS_HI) return POS_HI;
    if (r < POS_LO) return POS_LO;
    return r;
  endfunction

  function automatic pose_word_t advance_pose(odo_word_t w);
    pose_word_t p;
    longint dt, rate, spd, c, s, qw, qz;
    logic [63:0] mdt, am, lo, hi, u, dmag;
    logic [31:0] delta, half;
    bit clamped, dneg, sneg;
    dt = 0;
    clamped = 0;
    if (m_seen) begin
      dt = (longint'(w.sec) - longint'(m_prev_sec)) * 1000000000
           + (longint'(w.nsec) - longint'(m_prev_nsec));
      if (dt > DT_HI) begin
        dt = DT_HI;
        clamped = 1;
      end
      if (dt < DT_LO) begin
        dt = DT_LO;
        clamped = 1;
      end
    end
    m_prev_sec = w.sec;
    m_prev_nsec = w.nsec;
    m_seen = 1;
    dneg = dt < 0;
    mdt = umag(dt);
    rate = longint'(w.rate) - longint'($signed(m_drift));
    am = 64'(umag(rate)) * mdt;
    lo = (am & 64'hFFFFFFFF) * 64'd2935890503;
    hi = (am >> 32) * 64'd2935890503;
    u = hi + (lo >> 32);
    delta = 32'((u + 64'd32768) >> 16);
    if ((rate < 0) != dneg) delta = -delta;
    m_hdg = m_hdg + delta;
    spd = longint'(w.speed);
    sneg = (spd < 0) != dneg;
    dmag = (64'(umag(spd)) * mdt + 64'd500000000) / 64'd1000000000;
    rotate_trig(m_hdg, c, s);
    m_x = sat48(m_x, pos_step(dmag, sneg, c));
    m_y = sat48(m_y, pos_step(dmag, sneg, s));
    half = (m_hdg >> 1) | (m_hdg & 32'h80000000);
    rotate_trig(half, qw, qz);
    p.x = m_x[47:0];
    p.y = m_y[47:0];
    p.hdg = m_hdg;
    p.qz = qz[31:0];
    p.qw = qw[31:0];
    p.sec = w.sec;
    p.nsec = w.nsec;
    p.clamped = clamped;
    return p;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        in_taken = 0;
        if (pending_odo.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1;
          forward_speed <= pending_odo[0].speed;
          yaw_rate <= pending_odo[0].rate;
          stamp_sec <= pending_odo[0].sec;
          stamp_nsec <= pending_odo[0].nsec;
        end else begin
          in_valid <= 0;
        end
      end
      out_ready <= $urandom_range(99) >= out_stall_pct;
      if (!cfg_valid || cfg_taken) begin
        cfg_taken = 0;
        if (pending_cfg.size() > 0) begin
          cfg_valid <= 1;
          cfg_data <= pending_cfg[0];
        end else begin
          cfg_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_word_t got, exp_p;
    bit hit;
    if (!rst) begin
      hit = 0;
      if (cfg_valid && cfg_ready) begin
        m_drift = cfg_data;
        void'(pending_cfg.pop_front());
        cfg_taken = 1;
        hit = 1;
      end
      if (in_valid && in_ready) begin
        expected_pose.push_back(advance_pose(pending_odo.pop_front()));
        in_taken = 1;
        hit = 1;
      end
      if (out_valid && out_ready) begin
        hit = 1;
        got = '{pos_x, pos_y, heading, quat_z, quat_w, out_sec, out_nsec, step_clamped};
        if (expected_pose.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_p = expected_pose.pop_front();
          if (got.x !== exp_p.x) begin
            $display("%0t: pos_x exp %0d got %0d", $time, exp_p.x, got.x); errors++;
          end
          if (got.y !== exp_p.y) begin
            $display("%0t: pos_y exp %0d got %0d", $time, exp_p.y, got.y); errors++;
          end
          if (got.hdg !== exp_p.hdg) begin
            $display("%0t: heading exp %h got %h", $time, exp_p.hdg, got.hdg); errors++;
          end
          if (got.qz !== exp_p.qz) begin
            $display("%0t: quat_z exp %0d got %0d", $time, exp_p.qz, got.qz); errors++;
          end
          if (got.qw !== exp_p.qw) begin
            $display("%0t: quat_w exp %0d got %0d", $time, exp_p.qw, got.qw); errors++;
          end
          if (got.sec !== exp_p.sec || got.nsec !== exp_p.nsec) begin
            $display("%0t: stamp exp %0d.%0d got %0d.%0d", $time, exp_p.sec,
                     exp_p.nsec, got.sec, got.nsec);
            errors++;
          end
          if (got.clamped !== exp_p.clamped) begin
            $display("%0t: step_clamped exp %b got %b", $time, exp_p.clamped,
                     got.clamped);
            errors++;
          end
        end
      end
      idle_cycles <= hit ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("[planar_dead_reckoning] ERROR");
        $finish;
      end
    end
  end

  logic [31:0] clk_sec = 0;
  logic [29:0] clk_nsec = 0;

  function automatic odo_word_t rand_word(bit wild);
    odo_word_t w;
    longint ns;
    w.speed = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(0, 2 * 655360)) - 655360;
    w.rate = $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(0, 2 * 262144)) - 262144;
    if (wild) begin
      w.sec = $urandom;
      w.nsec = $urandom_range(3) == 0 ? 30'($urandom) : 30'($urandom_range(999999999));
    end else begin
      ns = longint'(clk_nsec) + $urandom_range(2000000);
      w.sec = clk_sec + 32'(ns / 1000000000);
      w.nsec = 30'(ns % 1000000000);
      if ($urandom_range(9) == 0) w.sec = w.sec + $urandom_range(3);
    end
    clk_sec = w.sec;
    clk_nsec = w.nsec;
    return w;
  endfunction

  task automatic push(logic [31:0] s, logic [31:0] r, logic [31:0] sec, logic [29:0] ns);
    pending_odo.push_back('{s, r, sec, ns});
    clk_sec = sec;
    clk_nsec = ns;
  endtask

  task automatic drain();
    while (pending_odo.size() > 0 || expected_pose.size() > 0 || pending_cfg.size() > 0
           || cfg_valid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed
    push(32'sh00010000, 32'sh00010000, 32'd5, 30'd0);
    push(32'sh00010000, 32'sh00010000, 32'd5, 30'd1000000);
    push(32'h7FFFFFFF, 32'h7FFFFFFF, 32'd5, 30'd2000000);
    push(32'h80000000, 32'h80000000, 32'd5, 30'd3000000);
    push(32'h7FFFFFFF, 32'h80000000, 32'd9, 30'd0);
    push(32'h80000000, 32'h7FFFFFFF, 32'd0, 30'd0);
    push(32'sh00020000, 32'sh00008000, 32'd0, 30'd500000);
    push(32'sh00020000, 32'sh00008000, 32'd0, 30'd100000);
    push(32'sh00010000, 32'sh00030000, 32'd0, 30'h3FFFFFFF);
    push(32'h7FFFFFFF, 32'h0, 32'd2, 30'h3FFFFFFF);
    push(32'h7FFFFFFF, 32'h0, 32'd4, 30'h3FFFFFFF);
    push(32'h7FFFFFFF, 32'h0, 32'd6, 30'h3FFFFFFF);
    push(32'h7FFFFFFF, 32'h0, 32'd8, 30'h3FFFFFFF);
    push(32'h0, 32'h12345678, 32'hFFFFFFFF, 30'd999999999);
    push(32'h0, 32'h0, 32'hFFFFFFFF, 30'd999999999);
    drain();
    pending_cfg.push_back(32'h7FFFFFFF);
    drain();
    push(32'sh00010000, 32'h80000000, clk_sec, clk_nsec + 30'd1000);
    push(32'sh00010000, 32'h7FFFFFFF, clk_sec, clk_nsec + 30'd2000000);
    drain();
    pending_cfg.push_back(32'h80000000);
    drain();
    push(32'sh00010000, 32'h7FFFFFFF, clk_sec, clk_nsec + 30'd2000000);
    push(32'sh00010000, 32'h80000000, clk_sec, clk_nsec + 30'd1000000);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 67; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 67; end
        default: begin in_idle_pct = 31; out_stall_pct = 31; end
      endcase
      pending_cfg.push_back(ph == 0 ? 32'h0 : $urandom_range(3) == 0 ? $urandom
                            : $signed($urandom_range(0, 65536)) - 32768);
      drain();
      for (int i = 0; i < 100; i++)
        pending_odo.push_back(rand_word($urandom_range(19) == 0));
      drain();
    end
    if (errors == 0) $display("[planar_dead_reckoning] OK");
    else $display("[planar_dead_reckoning] ERROR");
    $finish;
  end
endmodule
